>>> design/euler_2d_flux_macros.svh
// Assertion macros for the checker file of the flux block.
`ifndef EULER_2D_FLUX_MACROS_SVH
`define EULER_2D_FLUX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define E2F_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define E2F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycle.
`define E2F_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/e2f_pkg.sv
// Package with the payload types and constants of the Euler flux block.
package e2f_pkg;

    // Width of every fixed-point field.
    localparam int DATA_W = 32;

    // Flux direction codes.
    localparam logic DIR_X = 1'b0;
    localparam logic DIR_Y = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] density;
        logic signed [DATA_W-1:0] momentum_x;
        logic signed [DATA_W-1:0] momentum_y;
        logic signed [DATA_W-1:0] total_energy;
    } e2f_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] flux_mass;
        logic signed [DATA_W-1:0] flux_mom_x;
        logic signed [DATA_W-1:0] flux_mom_y;
        logic signed [DATA_W-1:0] flux_energy;
        logic                     error_flag;
    } e2f_out_t;

    // Per-item fields that ride alongside the arithmetic pipeline.
    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] flux_mass;
        logic                     bad_density;
    } e2f_side_t;

endpackage

>>> design/e2f_div.sv
// Pipelined rounding divider with saturation to a signed quotient field.
module e2f_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int Q_W   = 32
) (
    input  logic                    aclk,
    input  logic                    ce,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic signed [Q_W-1:0]   quo,
    output logic                    sat
);

    localparam int NX_W  = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 2;
    localparam int DD_W  = DEN_W + 1;
    localparam int CMP_W = (NX_W > DD_W + Q_W) ? NX_W : (DD_W + Q_W);

    logic [NUM_W-1:0] mag;
    logic [NX_W-1:0]  nn_reg;
    logic [DD_W-1:0]  dd0_reg;
    logic             neg0_reg;

    logic [DD_W-1:0]  rem_reg [0:Q_W];
    logic [DD_W-1:0]  dd_reg  [0:Q_W];
    logic [Q_W-1:0]   low_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             neg_reg [0:Q_W];
    logic             ovf_reg [0:Q_W];

    logic [Q_W-1:0]       qf;
    logic                 sat_next;
    logic signed [Q_W-1:0] quo_next;
    logic signed [Q_W-1:0] quo_reg;
    logic                  sat_reg;

    // Rounding to nearest is folded in: q = floor((2|n| + d) / (2d)).
    assign mag = num[NUM_W-1] ? (~num + 1'b1) : num;

    always_ff @(posedge aclk) begin
        if (ce) begin
            nn_reg   <= (NX_W'(mag) << 1) + NX_W'(den);
            dd0_reg  <= {den, 1'b0};
            neg0_reg <= num[NUM_W-1];
        end
    end

    // Overflow check: the quotient needs more than Q_W bits.
    always_ff @(posedge aclk) begin
        if (ce) begin
            ovf_reg[0] <= CMP_W'(nn_reg) >= (CMP_W'(dd0_reg) << Q_W);
            rem_reg[0] <= DD_W'(nn_reg >> Q_W);
            low_reg[0] <= nn_reg[Q_W-1:0];
            q_reg[0]   <= '0;
            dd_reg[0]  <= dd0_reg;
            neg_reg[0] <= neg0_reg;
        end
    end

    // One quotient bit per stage, restoring compare and subtract.
    for (genvar j = 1; j <= Q_W; j++) begin : g_step
        logic [DD_W:0] trial;
        logic          ge;

        assign trial = {rem_reg[j-1], low_reg[j-1][Q_W-1]};
        assign ge    = trial >= {1'b0, dd_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j] <= ge ? DD_W'(trial - {1'b0, dd_reg[j-1]}) : DD_W'(trial);
                low_reg[j] <= low_reg[j-1] << 1;
                q_reg[j]   <= {q_reg[j-1][Q_W-2:0], ge};
                dd_reg[j]  <= dd_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // Apply the sign and clamp to the signed range.
    always_comb begin
        qf       = q_reg[Q_W];
        sat_next = ovf_reg[Q_W] ||
                   (neg_reg[Q_W] ? (qf[Q_W-1] && (qf[Q_W-2:0] != '0)) : qf[Q_W-1]);
        if (sat_next) begin
            quo_next = neg_reg[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            quo_next = neg_reg[Q_W] ? $signed(~qf + 1'b1) : $signed(qf);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

>>> design/euler_2d_flux.sv
// Top level of the 2D compressible Euler flux pipeline.
//
// Usage: one cell's conserved variables enter on the s_ channel as a
// transfer of e2f_in_t; one flux vector leaves on the m_ channel as a
// transfer of e2f_out_t. action selects the x-flux F or the y-flux G.
// Both channels use valid and ready.
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline is an input register, four stages of multiply and add, and
// the divider's DATA_W + 3 stages, which resolve one quotient bit per
// stage.
// A non-positive density sets error_flag and drives the three momentum and
// energy fields to the most positive value; any clamped field sets it too.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls, the whole pipeline holds in place and s_ready
// drops, so nothing is lost or repeated; s_ready is high whenever the
// output register is empty or being taken.
module euler_2d_flux
    import e2f_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  e2f_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output e2f_out_t m_data
);

    localparam int W    = DATA_W;
    localparam int LAT  = W + 8;
    localparam int N1_W = 2 * W + 3;
    localparam int P3_W = 2 * W + 4;
    localparam int PL_W = 2 * W + 1;
    localparam int PH_W = 2 * W + 4;
    localparam int N3_W = 3 * W + 4;
    localparam int D1_W = W + 3;
    localparam int D3_W = 2 * W + 3;

    logic ce;
    logic      valid_reg [0:LAT-1];
    e2f_side_t side_reg  [0:LAT-1];
    e2f_side_t side_next;

    // Stage 0: input register.
    e2f_in_t in_reg;

    // Stage 1: products.
    logic signed [2*W-1:0] a_reg, b_reg, c1_reg, er_reg, rr_reg;
    logic signed [W-1:0]   mx1_reg, my1_reg, rho1_reg;

    // Stage 2: numerators and denominators.
    logic signed [N1_W-1:0] n1_2_reg;
    logic signed [P3_W-1:0] n3p_reg;
    logic signed [2*W-1:0]  c2_reg;
    logic        [D1_W-1:0] d1_2_reg;
    logic        [W-1:0]    d2_2_reg;
    logic        [D3_W-1:0] d3_2_reg;
    logic signed [W-1:0]    along_reg;
    logic signed [2*W-1:0]  along_sq, across_sq;
    logic signed [W-1:0]    along_sel;

    // Stage 3: partial products of the energy numerator.
    logic signed [PL_W-1:0] plo_reg;
    logic signed [PH_W-1:0] phi_reg;
    logic signed [N1_W-1:0] n1_3_reg;
    logic signed [2*W-1:0]  c3_reg;
    logic        [D1_W-1:0] d1_3_reg;
    logic        [W-1:0]    d2_3_reg;
    logic        [D3_W-1:0] d3_3_reg;
    logic        [W-1:0]    n3p_lo;
    logic signed [W+3:0]    n3p_hi;

    // Stage 4: full energy numerator.
    logic signed [N3_W-1:0] n3_reg;
    logic signed [N1_W-1:0] n1_4_reg;
    logic signed [2*W-1:0]  c4_reg;
    logic        [D1_W-1:0] d1_4_reg;
    logic        [W-1:0]    d2_4_reg;
    logic        [D3_W-1:0] d3_4_reg;

    logic signed [W-1:0] f1, f2, f3;
    logic                sat1, sat2, sat3;
    e2f_side_t           side_out;

    // The whole pipeline advances unless a finished result is held.
    assign ce      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = ce;
    assign m_valid = valid_reg[LAT-1];

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k < LAT; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Side fields: direction, mass flux and the density check.
    always_comb begin
        side_next.action      = s_data.action;
        side_next.flux_mass   = (s_data.action == DIR_Y) ? s_data.momentum_y
                                                         : s_data.momentum_x;
        side_next.bad_density = s_data.density[W-1] || (s_data.density == '0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            in_reg <= s_data;
        end
    end

    // Stage 1: the five square and cross products.
    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg    <= (2*W)'(in_reg.momentum_x) * (2*W)'(in_reg.momentum_x);
            b_reg    <= (2*W)'(in_reg.momentum_y) * (2*W)'(in_reg.momentum_y);
            c1_reg   <= (2*W)'(in_reg.momentum_x) * (2*W)'(in_reg.momentum_y);
            er_reg   <= (2*W)'(in_reg.total_energy) * (2*W)'(in_reg.density);
            rr_reg   <= (2*W)'(in_reg.density) * (2*W)'(in_reg.density);
            mx1_reg  <= in_reg.momentum_x;
            my1_reg  <= in_reg.momentum_y;
            rho1_reg <= in_reg.density;
        end
    end

    // Stage 2: normal momentum numerator (2*E*rho + 4*along^2 - across^2) and
    // the energy term 7*E*rho - mx^2 - my^2.
    always_comb begin
        along_sq  = (side_reg[1].action == DIR_Y) ? b_reg : a_reg;
        across_sq = (side_reg[1].action == DIR_Y) ? a_reg : b_reg;
        along_sel = (side_reg[1].action == DIR_Y) ? my1_reg : mx1_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            n1_2_reg  <= (N1_W'(er_reg) <<< 1) + (N1_W'(along_sq) <<< 2) - N1_W'(across_sq);
            n3p_reg   <= (P3_W'(er_reg) <<< 3) - P3_W'(er_reg) - P3_W'(a_reg) - P3_W'(b_reg);
            c2_reg    <= c1_reg;
            d1_2_reg  <= (D1_W'(unsigned'(rho1_reg)) << 2) + D1_W'(unsigned'(rho1_reg));
            d2_2_reg  <= rho1_reg;
            d3_2_reg  <= (D3_W'(unsigned'(rr_reg)) << 2) + D3_W'(unsigned'(rr_reg));
            along_reg <= along_sel;
        end
    end

    // Stage 3: split the energy term so each product stays word sized.
    assign n3p_lo = n3p_reg[W-1:0];
    assign n3p_hi = n3p_reg[P3_W-1:W];

    always_ff @(posedge aclk) begin
        if (ce) begin
            plo_reg  <= PL_W'($signed({1'b0, n3p_lo})) * PL_W'(along_reg);
            phi_reg  <= PH_W'(n3p_hi) * PH_W'(along_reg);
            n1_3_reg <= n1_2_reg;
            c3_reg   <= c2_reg;
            d1_3_reg <= d1_2_reg;
            d2_3_reg <= d2_2_reg;
            d3_3_reg <= d3_2_reg;
        end
    end

    // Stage 4: recombine the partial products.
    always_ff @(posedge aclk) begin
        if (ce) begin
            n3_reg   <= (N3_W'(phi_reg) <<< W) + N3_W'(plo_reg);
            n1_4_reg <= n1_3_reg;
            c4_reg   <= c3_reg;
            d1_4_reg <= d1_3_reg;
            d2_4_reg <= d2_3_reg;
            d3_4_reg <= d3_3_reg;
        end
    end

    // Three dividers of equal latency.
    e2f_div #(.NUM_W(N1_W), .DEN_W(D1_W), .Q_W(W)) u_div_normal (
        .aclk (aclk),
        .ce   (ce),
        .num  (n1_4_reg),
        .den  (d1_4_reg),
        .quo  (f1),
        .sat  (sat1)
    );

    e2f_div #(.NUM_W(2*W), .DEN_W(W), .Q_W(W)) u_div_cross (
        .aclk (aclk),
        .ce   (ce),
        .num  (c4_reg),
        .den  (d2_4_reg),
        .quo  (f2),
        .sat  (sat2)
    );

    e2f_div #(.NUM_W(N3_W), .DEN_W(D3_W), .Q_W(W)) u_div_energy (
        .aclk (aclk),
        .ce   (ce),
        .num  (n3_reg),
        .den  (d3_4_reg),
        .quo  (f3),
        .sat  (sat3)
    );

    // Output assembly from the registered quotients.
    assign side_out = side_reg[LAT-1];

    always_comb begin
        m_data.flux_mass = side_out.flux_mass;
        if (side_out.bad_density) begin
            m_data.flux_mom_x  = {1'b0, {(W-1){1'b1}}};
            m_data.flux_mom_y  = {1'b0, {(W-1){1'b1}}};
            m_data.flux_energy = {1'b0, {(W-1){1'b1}}};
            m_data.error_flag  = 1'b1;
        end else begin
            m_data.flux_mom_x  = (side_out.action == DIR_Y) ? f2 : f1;
            m_data.flux_mom_y  = (side_out.action == DIR_Y) ? f1 : f2;
            m_data.flux_energy = f3;
            m_data.error_flag  = sat1 || sat2 || sat3;
        end
    end

endmodule

>>> design/e2f_checker.sv
// Port-level checker for the Euler flux block and its bind.
`include "euler_2d_flux_macros.svh"

module e2f_checker
    import e2f_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input e2f_out_t m_data
);

    // A held result stays offered.
    `E2F_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")

    // A held result keeps its payload.
    `E2F_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_data), "m_data changed while stalled")

    // Input can be taken exactly when the output register can move.
    `E2F_ASSERT_NOW(a_ready_link, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready), "s_ready does not follow the output stage")

    // Reset empties the pipeline.
    `E2F_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid, "m_valid high right after reset")

endmodule

bind euler_2d_flux e2f_checker u_e2f_checker (.*);
